// File: sv/lzrd_pkg.sv
package lzrd_pkg;

   // Ring geometry and stream format
   localparam int RING_DEPTH = 4096;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int MAX_RUN    = 18;
   localparam int MIN_RUN    = 3;
   localparam int TOKENS_PER_FLAG = 8;
   localparam logic [RING_AW-1:0] RING_START = RING_AW'(RING_DEPTH - MAX_RUN);
   localparam logic [7:0] FILL_BYTE = 8'h20;

   // Copy length counter holds up to MAX_RUN
   localparam int RUN_W = $clog2(MAX_RUN + 1);

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic soft_reset;
      logic load_low;
      logic load_ref;
      logic load_lit;
      logic rd;
      logic rd_last;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic p1_valid;
      logic stage_free;
   } stat_type;

endpackage

// File: sv/lzss_ring_decoder.sv
// LZSS decoder with a 4096-byte history ring, taking one compressed byte per
// transfer and giving decompressed bytes one per transfer, run_last marking
// the last byte caused by an input byte. A flag byte or the first byte of a
// reference is only stored; for a reference of length L (3 to 18), the single
// read port of the ring memory sets the pace at one copied byte per cycle
// while the output takes bytes, and the block takes the next input byte once
// the ring write of the last byte is done, while that byte may still wait in
// the output register. The ring needs no clearing pass: a fill count since
// the last reset marks which entries were written, and unwritten ones read as
// spaces, so the block is ready right after reset and after the end-of-stream
// byte. A byte flagged end_of_stream returns the block to its reset state
// once its output bytes are written; a partial token is dropped.
module lzss_ring_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lzrd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lzrd_pkg::rsp_type rsp_data
);
   import lzrd_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   lzrd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .stat     (stat),
      .cmd      (cmd)
   );

   lzrd_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

// File: sv/lzrd_ram.sv
module lzrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port; read data holds when idle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: sv/lzrd_ctrl.sv
module lzrd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lzrd_pkg::req_type req_data,
   input  lzrd_pkg::stat_type stat,
   output lzrd_pkg::cmd_type cmd
);
   import lzrd_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      COPY,
      DRAIN
   } state_type;

   localparam logic [1:0] PHASE_START = 2'd0;
   localparam logic [1:0] PHASE_REF   = 2'd1;

   state_type        state_ff, state_in;
   logic [7:0]       flags_ff, flags_in;
   logic [3:0]       tokens_ff, tokens_in;
   logic [1:0]       phase_ff, phase_in;
   logic [RUN_W-1:0] cnt_ff, cnt_in;
   logic             eos_ff, eos_in;
   logic             accept;

   assign req_ready = (state_ff == IDLE);
   assign accept    = req_valid && req_ready;

   // Decode tokens and sequence copies
   always_comb begin
      state_in  = state_ff;
      flags_in  = flags_ff;
      tokens_in = tokens_ff;
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      eos_in    = eos_ff;
      cmd       = '0;
      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               priority if (tokens_ff == 4'd0) begin
                  flags_in  = req_data.in_byte;
                  tokens_in = 4'(TOKENS_PER_FLAG);
                  phase_in  = PHASE_START;
               end else if (phase_ff == PHASE_START && flags_ff[0]) begin
                  cmd.load_lit = 1'b1;
                  flags_in     = {1'b0, flags_ff[7:1]};
                  tokens_in    = tokens_ff - 4'd1;
                  phase_in     = PHASE_START;
                  state_in     = DRAIN;
               end else if (phase_ff == PHASE_START) begin
                  cmd.load_low = 1'b1;
                  phase_in     = PHASE_REF;
               end else begin
                  cmd.load_ref = 1'b1;
                  cnt_in       = RUN_W'(req_data.in_byte[3:0]) + RUN_W'(MIN_RUN);
                  flags_in     = {1'b0, flags_ff[7:1]};
                  tokens_in    = tokens_ff - 4'd1;
                  phase_in     = PHASE_START;
                  state_in     = COPY;
               end
               // Close the stream now if nothing is left to write, else after drain
               if (req_data.end_of_stream) begin
                  if (state_in == IDLE) begin
                     cmd.soft_reset = 1'b1;
                     flags_in       = '0;
                     tokens_in      = '0;
                     phase_in       = PHASE_START;
                  end else begin
                     eos_in = 1'b1;
                  end
               end
            end
         end
         COPY: begin
            if (stat.stage_free) begin
               cmd.rd      = 1'b1;
               cmd.rd_last = (cnt_ff == RUN_W'(1));
               cnt_in      = cnt_ff - RUN_W'(1);
               if (cnt_ff == RUN_W'(1)) begin
                  state_in = DRAIN;
               end
            end
         end
         DRAIN: begin
            if (!stat.p1_valid) begin
               state_in = IDLE;
               if (eos_ff) begin
                  cmd.soft_reset = 1'b1;
                  eos_in         = 1'b0;
                  flags_in       = '0;
                  tokens_in      = '0;
                  phase_in       = PHASE_START;
               end
            end
         end
         default: state_in = IDLE;
      endcase
   end

   // Hold state and token bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         flags_ff  <= '0;
         tokens_ff <= '0;
         phase_ff  <= PHASE_START;
         cnt_ff    <= '0;
         eos_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         flags_ff  <= flags_in;
         tokens_ff <= tokens_in;
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         eos_ff    <= eos_in;
      end
   end

endmodule

// File: sv/lzrd_dpath.sv
module lzrd_dpath (
   input  logic               clock,
   input  logic               reset,
   input  lzrd_pkg::cmd_type  cmd,
   output lzrd_pkg::stat_type stat,
   input  lzrd_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output lzrd_pkg::rsp_type  rsp_data
);
   import lzrd_pkg::*;

   logic [RING_AW-1:0] wp_ff, wp_in;
   logic [RING_AW:0]   fill_ff, fill_in;
   logic [RING_AW-1:0] rptr_ff, rptr_in;
   logic [7:0]         low_ff, low_in;
   logic               p1_valid_ff, p1_valid_in;
   logic               p1_lit_ff, p1_lit_in;
   logic               p1_last_ff, p1_last_in;
   logic [7:0]         lit_ff, lit_in;
   logic               byp_ff, byp_in;
   logic [7:0]         byp_data_ff, byp_data_in;
   logic               old_ff, old_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [7:0]         ram_q;
   logic [7:0]         p1_byte;
   logic               move;
   logic [RING_AW-1:0] rd_off;
   logic               rd_written;

   // Pick the pending byte: literal, forwarded write, untouched fill, or ring data
   always_comb begin
      priority if (p1_lit_ff) begin
         p1_byte = lit_ff;
      end else if (byp_ff) begin
         p1_byte = byp_data_ff;
      end else if (old_ff) begin
         p1_byte = FILL_BYTE;
      end else begin
         p1_byte = ram_q;
      end
   end

   assign move = p1_valid_ff && (!rsp_valid_ff || rsp_ready);

   // Entries from the start position up to the fill count hold written data
   assign rd_off     = rptr_ff - RING_START;
   assign rd_written = fill_ff[RING_AW] || ({1'b0, rd_off} < fill_ff);

   assign stat.p1_valid   = p1_valid_ff;
   assign stat.stage_free = !p1_valid_ff || move;

   lzrd_ram #(
      .WIDTH(8),
      .DEPTH(RING_DEPTH)
   ) u_ring (
      .clock  (clock),
      .wr_en  (move),
      .wr_addr(wp_ff),
      .wr_data(p1_byte),
      .rd_en  (cmd.rd),
      .rd_addr(rptr_ff),
      .rd_data(ram_q)
   );

   // Next values of the datapath registers
   always_comb begin
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      rptr_in      = rptr_ff;
      low_in       = low_ff;
      p1_valid_in  = p1_valid_ff;
      p1_lit_in    = p1_lit_ff;
      p1_last_in   = p1_last_ff;
      lit_in       = lit_ff;
      byp_in       = byp_ff;
      byp_data_in  = byp_data_ff;
      old_in       = old_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      // Drop the output once its transfer completes
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Advance the pending byte into the output and the ring
      if (move) begin
         rsp_valid_in    = 1'b1;
         rsp_in.out_byte = p1_byte;
         rsp_in.run_last = p1_last_ff;
         p1_valid_in     = 1'b0;
         wp_in           = wp_ff + RING_AW'(1);
         if (!fill_ff[RING_AW]) begin
            fill_in = fill_ff + (RING_AW+1)'(1);
         end
      end

      if (cmd.load_low) begin
         low_in = req_data.in_byte;
      end

      if (cmd.load_ref) begin
         rptr_in = {req_data.in_byte[7:4], low_ff};
      end

      if (cmd.load_lit) begin
         p1_valid_in = 1'b1;
         p1_lit_in   = 1'b1;
         p1_last_in  = 1'b1;
         lit_in      = req_data.in_byte;
      end

      // Issue a ring read; forward the byte written in the same cycle
      if (cmd.rd) begin
         p1_valid_in = 1'b1;
         p1_lit_in   = 1'b0;
         p1_last_in  = cmd.rd_last;
         rptr_in     = rptr_ff + RING_AW'(1);
         byp_in      = move && (rptr_ff == wp_ff);
         byp_data_in = p1_byte;
         old_in      = !rd_written;
      end

      if (cmd.soft_reset) begin
         wp_in   = RING_START;
         fill_in = '0;
      end
   end

   // Hold control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= RING_START;
         fill_ff      <= '0;
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rptr_ff     <= rptr_in;
      low_ff      <= low_in;
      p1_lit_ff   <= p1_lit_in;
      p1_last_ff  <= p1_last_in;
      lit_ff      <= lit_in;
      byp_ff      <= byp_in;
      byp_data_ff <= byp_data_in;
      old_ff      <= old_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: verif/lzss_ring_decoder_tb.sv
module lzss_ring_decoder_tb;
   import lzrd_pkg::*;

   localparam int PREDICT      = -1;        // row result comes from the decoder model
   localparam int IDLE_PCT     = 13;
   localparam int RAND_ITEMS   = 90;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int TIMEOUT      = 1_000_000;

   typedef enum logic [1:0] {
      TOK_START,
      TOK_OFFSET_HIGH
   } tok_phase_type;

   typedef struct {
      logic [7:0] in_byte;
      logic       eos;
      int         typed_n;   // number of known result bytes, or PREDICT
      logic [7:0] typed_b;   // every known result byte has this value
   } stim_row_type;

   localparam int DIR_ROWS = 24;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Decoder model state
   logic [7:0]         hist_ring [RING_DEPTH];
   logic [RING_AW-1:0] wr_pos;
   logic [7:0]         flag_bits;
   logic [3:0]         tokens_left;
   tok_phase_type      tok_phase;
   logic [7:0]         off_low;

   rsp_type step_out[$];      // bytes decoded from the current input byte
   rsp_type pending_out[$];   // bytes still owed by the block

   int   err_count = 0;
   int   sent_count = 0;
   logic calm = 1'b0;         // no idling on either side while set
   logic hold_req = 1'b0;
   logic hold_done = 1'b0;
   int   stall_left = 0;

   stim_row_type dir_rows [DIR_ROWS] = '{
      // all references; read the space-filled ring at both extremes
      '{8'h00, 1'b0, 0,       8'h00},
      '{8'h00, 1'b0, 0,       8'h00},
      '{8'h00, 1'b0, 3,       8'h20},
      '{8'hFF, 1'b0, 0,       8'h00},
      '{8'hFF, 1'b0, 18,      8'h20},
      // cut a reference after its first byte
      '{8'h12, 1'b1, 0,       8'h00},
      // all literals
      '{8'hFF, 1'b0, 0,       8'h00},
      '{8'h00, 1'b0, 1,       8'h00},
      '{8'hFF, 1'b0, 1,       8'hFF},
      '{8'h41, 1'b0, PREDICT, 8'h00},
      '{8'h42, 1'b0, PREDICT, 8'h00},
      '{8'h43, 1'b0, PREDICT, 8'h00},
      '{8'h44, 1'b0, PREDICT, 8'h00},
      '{8'h45, 1'b0, PREDICT, 8'h00},
      '{8'h46, 1'b0, PREDICT, 8'h00},
      // overlapping copy two bytes behind the write position, full length
      '{8'hFE, 1'b0, PREDICT, 8'h00},
      '{8'hF4, 1'b0, PREDICT, 8'h00},
      '{8'hFF, 1'b0, PREDICT, 8'h00},
      '{8'h7E, 1'b1, 1,       8'h7E},
      // end of stream on a flag byte
      '{8'h55, 1'b1, 0,       8'h00},
      // end of stream on the second byte of a reference
      '{8'h00, 1'b0, 0,       8'h00},
      '{8'h34, 1'b0, 0,       8'h00},
      '{8'h12, 1'b1, 5,       8'h20},
      '{8'hA5, 1'b0, 0,       8'h00}
   };

   lzss_ring_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // Return the model to its post-reset state
   function automatic void ring_clear();
      for (int i = 0; i < RING_DEPTH; i++) hist_ring[i] = FILL_BYTE;
      wr_pos      = RING_START;
      flag_bits   = '0;
      tokens_left = '0;
      tok_phase   = TOK_START;
      off_low     = '0;
   endfunction

   function automatic void ring_write(logic [7:0] b);
      rsp_type r;
      r.out_byte = b;
      r.run_last = 1'b0;
      step_out.push_back(r);
      hist_ring[wr_pos] = b;
      wr_pos = wr_pos + 1'b1;
   endfunction

   function automatic void next_token();
      flag_bits   = flag_bits >> 1;
      tokens_left = tokens_left - 1'b1;
      tok_phase   = TOK_START;
   endfunction

   // Decode one compressed byte into step_out
   function automatic void decode_byte(req_type r);
      logic [RING_AW-1:0] src;
      int                 run;
      step_out.delete();
      if (tokens_left == 0) begin
         flag_bits   = r.in_byte;
         tokens_left = 4'(TOKENS_PER_FLAG);
         tok_phase   = TOK_START;
      end else if (tok_phase == TOK_START) begin
         if (flag_bits[0]) begin
            ring_write(r.in_byte);
            next_token();
         end else begin
            off_low   = r.in_byte;
            tok_phase = TOK_OFFSET_HIGH;
         end
      end else begin
         src = {r.in_byte[7:4], off_low};
         run = int'(r.in_byte[3:0]) + MIN_RUN;
         for (int k = 0; k < run; k++) begin
            ring_write(hist_ring[src]);
            src = src + 1'b1;
         end
         next_token();
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].run_last = 1'b1;
      if (r.end_of_stream) ring_clear();
   endfunction

   task automatic report(string what);
      $display("ERROR @%0t: %s", $time, what);
      err_count++;
   endtask

   // Offer one byte; the model runs when the transfer is committed
   task automatic send_item(logic [7:0] b, logic eos, int typed_n, logic [7:0] typed_b);
      req_type r;
      rsp_type t;
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      r.in_byte       = b;
      r.end_of_stream = eos;
      decode_byte(r);
      if (typed_n == PREDICT) begin
         foreach (step_out[i]) pending_out.push_back(step_out[i]);
      end else begin
         for (int i = 0; i < typed_n; i++) begin
            t.out_byte = typed_b;
            t.run_last = (i == typed_n - 1);
            pending_out.push_back(t);
         end
      end
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   // Drop valid and hold until the block owes nothing
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_out.size() != 0);
   endtask

   // One random stream: mostly well-formed groups, some noise, some cut short
   task automatic random_stream();
      int                 groups;
      logic               broken;
      logic               last;
      logic [7:0]         fl;
      logic [RING_AW-1:0] src;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(3, 12))
            send_item(8'($urandom), $urandom_range(0, 7) == 0, PREDICT, 8'h00);
         return;
      end
      broken = ($urandom_range(0, 9) == 0);
      groups = $urandom_range(1, 3);
      for (int g = 0; g < groups; g++) begin
         fl = 8'($urandom);
         send_item(fl, 1'b0, PREDICT, 8'h00);
         for (int t = 0; t < TOKENS_PER_FLAG; t++) begin
            last = (g == groups - 1) && (t == TOKENS_PER_FLAG - 1);
            if (fl[t]) begin
               send_item(8'($urandom), last, PREDICT, 8'h00);
            end else begin
               // mostly copy recent bytes, often overlapping the write position
               if ($urandom_range(0, 9) < 7)
                  src = wr_pos - RING_AW'($urandom_range(1, 24));
               else
                  src = RING_AW'($urandom);
               if (broken && $urandom_range(0, 3) == 0) begin
                  send_item(src[7:0], 1'b1, PREDICT, 8'h00);
                  return;
               end
               send_item(src[7:0], 1'b0, PREDICT, 8'h00);
               send_item({src[11:8], 4'($urandom)}, last, PREDICT, 8'h00);
            end
         end
      end
   endtask

   task automatic check_result(rsp_type got);
      rsp_type want;
      if (pending_out.size() == 0) begin
         report($sformatf("unexpected output byte %02h", got.out_byte));
         return;
      end
      want = pending_out.pop_front();
      if (got.out_byte !== want.out_byte)
         report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
      if (got.run_last !== want.run_last)
         report($sformatf("run_last %0b, want %0b", got.run_last, want.run_last));
   endtask

   // Output side: check each transfer, then pick the next ready
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) check_result(rsp_data);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (hold_req && !hold_done) begin
            stall_left = HOLD_CYCLES - 1;
            hold_done  = 1'b1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      #(TIMEOUT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      ring_clear();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed rows
      foreach (dir_rows[i])
         send_item(dir_rows[i].in_byte, dir_rows[i].eos, dir_rows[i].typed_n,
                   dir_rows[i].typed_b);
      wait_drained();

      // Random streams; the output side holds off early so the block backs up
      hold_req <= 1'b1;
      while (sent_count < DIR_ROWS + RAND_ITEMS) begin
         random_stream();
         if (sent_count >= DIR_ROWS + 40 && sent_count < DIR_ROWS + 80)
            calm <= 1'b1;
         else
            calm <= 1'b0;
         if (sent_count >= DIR_ROWS + 60 && sent_count < DIR_ROWS + 80)
            wait_drained();
      end
      calm <= 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: files.f
sv/lzrd_pkg.sv
sv/lzrd_ram.sv
sv/lzrd_ctrl.sv
sv/lzrd_dpath.sv
sv/lzss_ring_decoder.sv
verif/lzss_ring_decoder_tb.sv
